@@ hw/rtl/spims_pkg.sv @@
// Shared types, register codes and helper functions for the SPI master shifter.
`default_nettype none

package spims_pkg;

    localparam int WORD_W   = 32;
    localparam int BAUD_W   = 9;
    localparam int EDGE_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Register reset values
    localparam logic [BAUD_W-1:0] BAUD_RESET       = 9'd64;
    localparam logic [1:0]        CLOCK_MODE_RESET = 2'd0;
    localparam logic [1:0]        WORD_SIZE_RESET  = 2'd0;
    localparam logic              SAMPLE_END_RESET = 1'b1;

    // Word size codes; any other code runs 32 bits
    localparam logic [1:0] WS_8  = 2'd0;
    localparam logic [1:0] WS_16 = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAUD_DIVIDER  = 2'd0,
        CFG_CLOCK_MODE    = 2'd1,
        CFG_WORD_SIZE     = 2'd2,
        CFG_SAMPLE_AT_END = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_divider;
        logic [1:0]        clock_mode;
        logic [1:0]        word_size;
        logic              sample_at_end;
    } t_cfg;

    // Request from software and the pin, last field in the low bits
    typedef struct packed {
        logic              miso_level;
        logic              rx_take;
        logic [WORD_W-1:0] tx_word;
        logic              tx_write;
    } t_item;

    // Result shown after each tick, last field in the low bits
    typedef struct packed {
        logic              overflow;
        logic              busy_res;
        logic              rx_full;
        logic [WORD_W-1:0] rx_word;
        logic              mosi_level;
        logic              sclk_level;
    } t_result;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_count;
        logic [EDGE_W-1:0] edge_count;
        logic [WORD_W-1:0] tx_shift;
        logic [WORD_W-1:0] rx_shift;
        logic [WORD_W-1:0] rx_hold;
        logic              rx_full;
        logic              overflow;
        logic              busy;
        logic              clock_level;
        logic              mosi;
    } t_state;

    function automatic logic [EDGE_W-1:0] word_bits(input logic [1:0] ws);
        logic [EDGE_W-1:0] n;
        case (ws)
            WS_8:    n = 7'd8;
            WS_16:   n = 7'd16;
            default: n = 7'd32;
        endcase
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] word_mask(input logic [1:0] ws);
        logic [WORD_W-1:0] m;
        case (ws)
            WS_8:    m = 32'h0000_00FF;
            WS_16:   m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Top bit of the active word
    function automatic logic word_msb(input logic [WORD_W-1:0] w, input logic [1:0] ws);
        logic b;
        case (ws)
            WS_8:    b = w[7];
            WS_16:   b = w[15];
            default: b = w[31];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spims_step.sv @@
// Next-state logic for one peripheral clock tick of the SPI shifter.
`default_nettype none

module spims_step
    import spims_pkg::*;
(
    input  var t_state i_state,
    input  var t_cfg   i_cfg,
    input  var t_item  i_item,
    output t_state     o_state
);

    always_comb begin
        t_state            nx;
        logic [EDGE_W-1:0] n;
        logic [WORD_W-1:0] m;
        logic              late;
        logic [7:0]        off;
        logic [7:0]        total;
        logic [7:0]        e;
        logic [7:0]        ep1;
        logic [7:0]        d;
        logic [WORD_W-1:0] loaded;

        nx     = i_state;
        n      = word_bits(i_cfg.word_size);
        m      = word_mask(i_cfg.word_size);
        late   = i_cfg.clock_mode[0];
        off    = {7'd0, ~late} + {7'd0, i_cfg.sample_at_end};
        total  = {n, 1'b0} + {7'd0, (off == 8'd2)};
        e      = {1'b0, i_state.edge_count};
        ep1    = e + 8'd1;
        d      = e - off;
        loaded = i_item.tx_word & m;

        // a read empties the buffer before anything else this tick
        if (i_item.rx_take) begin
            nx.rx_full = 1'b0;
        end

        if (i_state.busy) begin
            if (i_state.baud_count >= i_cfg.baud_divider) begin
                nx.baud_count = '0;

                if (e >= off && !d[0] && d[7:1] < n) begin
                    nx.rx_shift = {i_state.rx_shift[WORD_W-2:0], i_item.miso_level};
                end

                if (e < {n, 1'b0}) begin
                    nx.clock_level = ~i_state.clock_level;
                end

                if ((late && e[0] && ep1[7:1] < n) || (!late && !e[0] && e[7:1] < n)) begin
                    nx.mosi     = word_msb(i_state.tx_shift, i_cfg.word_size);
                    nx.tx_shift = {i_state.tx_shift[WORD_W-2:0], 1'b0} & m;
                end

                nx.edge_count = i_state.edge_count + 7'd1;
                if (ep1 >= total) begin
                    nx.rx_hold    = nx.rx_shift & m;
                    nx.overflow   = i_state.overflow | nx.rx_full;
                    nx.rx_full    = 1'b1;
                    nx.busy       = 1'b0;
                    nx.edge_count = '0;
                end
            end else begin
                nx.baud_count = i_state.baud_count + 9'd1;
            end
        end else if (i_item.tx_write) begin
            nx.rx_shift    = '0;
            nx.baud_count  = '0;
            nx.edge_count  = '0;
            nx.busy        = 1'b1;
            nx.clock_level = i_cfg.clock_mode[1];
            if (late) begin
                nx.mosi     = word_msb(loaded, i_cfg.word_size);
                nx.tx_shift = {loaded[WORD_W-2:0], 1'b0} & m;
            end else begin
                nx.tx_shift = loaded;
            end
        end

        // idle clock follows the polarity setting
        if (!nx.busy) begin
            nx.clock_level = i_cfg.clock_mode[1];
        end

        o_state = nx;
    end

endmodule

`default_nettype wire

@@ hw/rtl/spi_master_shifter.sv @@
// Top level of the SPI master shifter: request register, tick logic, result register.
`default_nettype none

// SPI master shifter. Each request on the slave stream is one peripheral
// clock tick: a possible transmit-buffer write, a possible receive-buffer
// read and the MISO pin level. Each request yields exactly one result on
// the master stream: SCLK and MOSI levels, the receive buffer, receive-full,
// busy and the sticky overflow flag, all as they stand after that tick.
// A write while idle starts a transfer of 8, 16 or 32 bits, MSB first;
// SCLK runs at the tick rate divided by 2*(baud_divider+1). Requests are
// taken every cycle while the output is not stalled: a request is
// registered, then, once the result register is free, the tick logic
// updates the shifter state and loads the result register. The single
// tick-logic stage sets the rate of one request per cycle when the output
// is not stalled. When the result register is held by a stalled consumer
// the request register still takes one more request before ready drops.
// Configuration registers are written through the plain write port; write
// them only while no request is in flight and no transfer runs.

module spi_master_shifter
    import spims_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    // configuration write port
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,

    // request stream
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] tx_write, [32:1] tx_word, [33] rx_take, [34] miso_level, [39:35] zero
    input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,

    // result stream
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // [0] sclk_level, [1] mosi_level, [33:2] rx_word, [34] rx_full,
    // [35] busy_res, [36] overflow, [39:37] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int ITEM_W = $bits(t_item);
    localparam int RES_W  = $bits(t_result);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;

    logic    out_free;
    logic    advance;
    logic    in_accept;

    // the result register frees when empty or being drained this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baud_divider  <= BAUD_RESET;
            r_cfg.clock_mode    <= CLOCK_MODE_RESET;
            r_cfg.word_size     <= WORD_SIZE_RESET;
            r_cfg.sample_at_end <= SAMPLE_END_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BAUD_DIVIDER:  r_cfg.baud_divider  <= i_cfg_data[BAUD_W-1:0];
                CFG_CLOCK_MODE:    r_cfg.clock_mode    <= i_cfg_data[1:0];
                CFG_WORD_SIZE:     r_cfg.word_size     <= i_cfg_data[1:0];
                CFG_SAMPLE_AT_END: r_cfg.sample_at_end <= i_cfg_data[0];
            endcase
        end
    end

    // request register: hold while the tick stage is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= t_item'(s_axis_tdata[ITEM_W-1:0]);
        end
    end

    spims_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_state (n_state)
    );

    // shifter state advances one tick per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.sclk_level <= n_state.clock_level;
            r_out.mosi_level <= n_state.mosi;
            r_out.rx_word    <= n_state.rx_hold;
            r_out.rx_full    <= n_state.rx_full;
            r_out.busy_res   <= n_state.busy;
            r_out.overflow   <= n_state.overflow;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ hw/rtl/spims_checker.sv @@
// Port-level checks for the SPI master shifter and their binding.
`default_nettype none

module spims_checker
    import spims_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    input  wire                    s_axis_tready,
    input  wire                    m_axis_tvalid,
    input  wire                    m_axis_tready,
    input  wire  [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int OVF_BIT = 36;

    logic       r_last_ovf;
    logic [2:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // track requests in flight and the overflow flag last delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_last_ovf <= 1'b0;
        end else begin
            r_pending <= r_pending + {2'd0, in_acc} - {2'd0, out_acc};
            if (out_acc) begin
                r_last_ovf <= m_axis_tdata[OVF_BIT];
            end
        end
    end

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_last_ovf |-> m_axis_tdata[OVF_BIT])
        else $error("overflow flag dropped without reset");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("more than two requests in flight");

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request side stalled without result backpressure");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind spi_master_shifter spims_checker u_spims_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/spi_master_shifter_tb.sv @@
// Self-checking bench for the SPI master shifter: streams tick requests and checks every result.
module spi_master_shifter_tb;
    import spims_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_PHASE    = 1;

    // 32-bit word codes; the package names only the narrow ones
    localparam logic [1:0] WS_32   = 2'd2;
    localparam logic [1:0] WS_WIDE = 2'd3;

    localparam logic [BAUD_W-1:0] DIV_FASTEST = 9'd0;

    typedef enum int {
        MISO_LOW,
        MISO_HIGH,
        MISO_RANDOM
    } t_miso_src;

    // Tracks the shifter per tick and holds the pin states still to come back
    class spi_pin_tracker;
        logic [BAUD_W-1:0] divider;
        logic [1:0]        mode;
        logic [1:0]        size;
        logic              sample_end;
        logic [BAUD_W-1:0] baud_cnt;
        logic [EDGE_W-1:0] edge_cnt;
        logic [WORD_W-1:0] tx_sr;
        logic [WORD_W-1:0] rx_sr;
        logic [WORD_W-1:0] rx_buf;
        logic              full;
        logic              ovf;
        logic              busy;
        logic              sclk;
        logic              mosi;
        t_result           pin_states_due[$];
        int                errors;
        int                matched;
        int                words_done;
        int                overflow_hits;

        function new();
            divider       = BAUD_RESET;
            mode          = CLOCK_MODE_RESET;
            size          = WORD_SIZE_RESET;
            sample_end    = SAMPLE_END_RESET;
            baud_cnt      = '0;
            edge_cnt      = '0;
            tx_sr         = '0;
            rx_sr         = '0;
            rx_buf        = '0;
            full          = 1'b0;
            ovf           = 1'b0;
            busy          = 1'b0;
            sclk          = 1'b0;
            mosi          = 1'b0;
            errors        = 0;
            matched       = 0;
            words_done    = 0;
            overflow_hits = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BAUD_DIVIDER:  divider    = value[BAUD_W-1:0];
                CFG_CLOCK_MODE:    mode       = value[1:0];
                CFG_WORD_SIZE:     size       = value[1:0];
                CFG_SAMPLE_AT_END: sample_end = value[0];
                default:           ;
            endcase
        endfunction

        function int nbits();
            case (size)
                WS_8:    return 8;
                WS_16:   return 16;
                default: return 32;
            endcase
        endfunction

        function logic [WORD_W-1:0] active_mask();
            if (nbits() == 32)
                return '1;
            return (32'h1 << nbits()) - 32'h1;
        endfunction

        // Put the top bit of the shift register on MOSI and advance
        function void drive_mosi();
            int n;
            n    = nbits();
            mosi = tx_sr[n-1];
            tx_sr = (tx_sr << 1) & active_mask();
        endfunction

        function void advance_edge(logic miso);
            int n;
            int off;
            int total;
            int e;
            n     = nbits();
            off   = (mode[0] ? 0 : 1) + int'(sample_end);
            total = 2 * n + ((off == 2) ? 1 : 0);
            e     = int'(edge_cnt);
            if (e >= off && ((e - off) % 2) == 0 && ((e - off) / 2) < n)
                rx_sr = {rx_sr[WORD_W-2:0], miso};
            if (e < 2 * n)
                sclk = ~sclk;
            if (mode[0]) begin
                if ((e % 2) == 1 && ((e + 1) / 2) < n)
                    drive_mosi();
            end else if ((e % 2) == 0 && (e / 2) < n) begin
                drive_mosi();
            end
            edge_cnt = EDGE_W'(e + 1);
            if (e + 1 >= total) begin
                rx_buf = rx_sr & active_mask();
                if (full) begin
                    ovf = 1'b1;
                    overflow_hits++;
                end
                full     = 1'b1;
                busy     = 1'b0;
                edge_cnt = '0;
                baud_cnt = '0;
                words_done++;
            end
        endfunction

        // Apply one accepted request and queue the pin state it leaves
        function void take_request(t_item it);
            t_result r;
            if (it.rx_take)
                full = 1'b0;
            if (busy) begin
                if (baud_cnt >= divider) begin
                    baud_cnt = '0;
                    advance_edge(it.miso_level);
                end else begin
                    baud_cnt = baud_cnt + 1'b1;
                end
            end else if (it.tx_write) begin
                tx_sr    = it.tx_word & active_mask();
                rx_sr    = '0;
                baud_cnt = '0;
                edge_cnt = '0;
                busy     = 1'b1;
                sclk     = mode[1];
                if (mode[0])
                    drive_mosi();
            end
            if (!busy)
                sclk = mode[1];
            r.sclk_level = sclk;
            r.mosi_level = mosi;
            r.rx_word    = rx_buf;
            r.rx_full    = full;
            r.busy_res   = busy;
            r.overflow   = ovf;
            pin_states_due.push_back(r);
        endfunction

        function void compare(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pin_states_due.size() == 0) begin
                errors++;
                $error("result with no request waiting: %0h", got);
                return;
            end
            want = pin_states_due.pop_front();
            compare("sclk_level", WORD_W'(want.sclk_level), WORD_W'(got.sclk_level));
            compare("mosi_level", WORD_W'(want.mosi_level), WORD_W'(got.mosi_level));
            compare("rx_word", want.rx_word, got.rx_word);
            compare("rx_full", WORD_W'(want.rx_full), WORD_W'(got.rx_full));
            compare("busy_res", WORD_W'(want.busy_res), WORD_W'(got.busy_res));
            compare("overflow", WORD_W'(want.overflow), WORD_W'(got.overflow));
            matched++;
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   req_valid;
    wire                    req_ready;
    logic [IN_TDATA_W-1:0]  req_data;
    wire                    res_valid;
    logic                   res_ready;
    wire  [OUT_TDATA_W-1:0] res_data;

    // Stimulus-side controls and the settings count; quiet and hold_req are read by the receiver process
    bit quiet;
    bit hold_req;
    int settings_run;

    spi_pin_tracker book;

    spi_master_shifter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (req_ready),
        .s_axis_tdata  (req_data),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_item make_item(input logic wr, input logic [WORD_W-1:0] w,
                                        input logic take, input logic miso);
        t_item it;
        it.tx_write   = wr;
        it.tx_word    = w;
        it.rx_take    = take;
        it.miso_level = miso;
        return it;
    endfunction

    function automatic logic miso_value(input t_miso_src src);
        case (src)
            MISO_LOW:  return 1'b0;
            MISO_HIGH: return 1'b1;
            default:   return 1'($urandom);
        endcase
    endfunction

    // Mostly fast clocks so that many words fit in the run
    function automatic logic [BAUD_W-1:0] random_divider();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return BAUD_W'($urandom_range(0, 1));
            6, 7, 8:          return BAUD_W'($urandom_range(2, 3));
            default:          return BAUD_W'($urandom_range(4, 7));
        endcase
    endfunction

    // Offer one request, with an occasional gap in front, and hold it until taken.
    // Leave valid high afterwards so back-to-back requests need no extra edge.
    task automatic send_tick(input t_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= IN_TDATA_W'(it);
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        book.take_request(it);
    endtask

    // One register write; the trailing edge keeps the enable low between writes
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        book.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    // Write all four registers; junk in the unused data bits must be dropped
    task automatic configure(input logic [BAUD_W-1:0] div, input logic [1:0] cmode,
                             input logic [1:0] ws, input logic sae);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_BAUD_DIVIDER, div);
        write_reg(CFG_CLOCK_MODE, {junk[CFG_DATA_W-1:2], cmode});
        write_reg(CFG_WORD_SIZE, {junk[CFG_DATA_W-2:1], ws});
        write_reg(CFG_SAMPLE_AT_END, {junk[CFG_DATA_W-1:1], sae});
        settings_run++;
    endtask

    // Run out any transfer, drop valid, then wait until every result is back
    task automatic quiesce();
        while (book.busy)
            send_tick(make_item(1'b0, $urandom, $urandom_range(0, 7) == 0, 1'($urandom)));
        req_valid <= 1'b0;
        while (book.pin_states_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Start a word and tick until it completes. With poke set, every tick of
    // the transfer also writes the buffer, the completing tick included.
    task automatic shift_word(input logic [WORD_W-1:0] w, input t_miso_src src,
                              input logic poke, input logic take_all);
        send_tick(make_item(1'b1, w, take_all, miso_value(src)));
        while (book.busy)
            send_tick(make_item(poke, ~w, take_all, miso_value(src)));
    endtask

    // Writes land mostly while idle so transfers start often; some hit a busy shifter
    task automatic random_tick();
        logic              wr;
        logic [WORD_W-1:0] w;
        if (book.busy)
            wr = ($urandom_range(0, 7) == 0);
        else
            wr = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom;
        endcase
        send_tick(make_item(wr, w, $urandom_range(0, 5) == 0, 1'($urandom)));
    endtask

    // Receiver: random short stalls, one long hold on request, none when quiet
    initial begin
        forever begin
            if (hold_req) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                res_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Check every result the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_valid && res_ready)
            book.match_result(t_result'(res_data[$bits(t_result)-1:0]));
    end

    initial begin
        book         = new();
        settings_run = 0;
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BAUD_DIVIDER;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset mode, size and sampling at the fastest clock: one byte;
        // the upper word bits must not go out
        write_reg(CFG_BAUD_DIVIDER, DIV_FASTEST);
        shift_word(32'hFFFF_FF5A, MISO_RANDOM, 1'b0, 1'b0);
        quiesce();

        // Fastest clock: walk every clock mode with both sampling points,
        // all-ones and all-zeros bytes, and a read on every tick for half
        for (int m = 0; m < 4; m++) begin
            for (int s = 0; s < 2; s++) begin
                configure(DIV_FASTEST, 2'(m), WS_8, 1'(s));
                shift_word((m % 2) ? 32'h0000_00FF : 32'h0, (m % 2) ? MISO_HIGH : MISO_LOW,
                           1'b0, 1'(s));
                quiesce();
            end
        end

        // Wider words, including the unused size code that runs 32 bits
        configure(DIV_FASTEST, 2'd1, WS_16, 1'b1);
        shift_word(32'hFFFF_FFFF, MISO_HIGH, 1'b0, 1'b0);
        quiesce();
        configure(9'd1, 2'd2, WS_32, 1'b0);
        shift_word(32'h0, MISO_LOW, 1'b0, 1'b1);
        quiesce();
        configure(DIV_FASTEST, 2'd3, WS_WIDE, 1'b1);
        shift_word(32'hFFFF_FFFF, MISO_RANDOM, 1'b0, 1'b1);
        quiesce();

        // Buffer writes during a transfer and on its final tick are ignored;
        // a second word without a read in between raises the sticky overflow
        configure(DIV_FASTEST, 2'd0, WS_8, 1'b1);
        shift_word(32'h0000_003C, MISO_RANDOM, 1'b1, 1'b0);
        quiesce();
        shift_word(32'h0000_00C3, MISO_RANDOM, 1'b0, 1'b0);
        quiesce();
        send_tick(make_item(1'b0, '0, 1'b1, 1'b0));
        quiesce();

        // Random phases: fresh settings each time, one with a long receiver
        // hold, and the last with no idling at all
        for (int p = 0; p < RAND_PHASES; p++) begin
            quiet = (p == RAND_PHASES - 1);
            configure(random_divider(), 2'($urandom), 2'($urandom), 1'($urandom));
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) random_tick();
            quiesce();
        end

        $display("Checked %0d tick results; %0d words shifted, %0d of them overflowed.",
                 book.matched, book.words_done, book.overflow_hits);
        $display("Ran %0d register settings over all clock modes, word sizes and short dividers.",
                 settings_run);
        if (book.errors == 0 && book.pin_states_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("FAIL");
        $finish;
    end

endmodule
